// ----- sv/ordered_value_list_macros.svh -----
// Assertion macros shared by the ordered value list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OVL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered_value_list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered_value_list assertion failed");

`endif

// ----- sv/ovl_pkg.sv -----
// Types and operation codes for the ordered value list.
// No dependencies; imported by ovl_cell and ordered_value_list.
package ovl_pkg;

	typedef enum logic [1:0] {
		OP_APPEND   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic       success;
		logic       full_reject;
		logic [4:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic en;
		op_t  op;
	} ovl_cmd_t;

endpackage

// ----- sv/ovl_cell.sv -----
// One list position: holds one entry, compares it and takes its right neighbor on removal.
// Depends on ovl_pkg.
module ovl_cell
	import ovl_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  ovl_cmd_t              cmd,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [VALUE_BITS-1:0] next_data,
	input  logic                  match_in,
	output logic                  match_out,
	output logic [VALUE_BITS-1:0] data
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [VALUE_BITS-1:0] data_q;
	logic                  live;
	logic                  hit;

	assign live      = MY_IDX < cnt;
	assign hit       = live && (data_q == value);
	assign match_out = match_in | hit;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.op == OP_APPEND && cnt == MY_IDX) begin
				data_q <= value;
			end else if (cmd.op == OP_REMOVE && match_out) begin
				data_q <= next_data;
			end
		end
	end

endmodule

// ----- sv/ordered_value_list.sv -----
// Ordered value list: a bounded list of signed values with append, remove,
// contains and clear, built as a row of cells that shift toward the head.
//
// The input channel (in_valid, in_ready, in_item) carries one item with an
// operation code and a value. The output channel (out_valid, out_ready,
// out_item) returns one item per input item with success, full_reject and
// the entry count after the operation.
// Every cell compares its entry with the value in the same cycle; a match
// ripples along the row so that only the first match and the cells behind
// it shift. The whole operation completes in the cycle of acceptance.
// The result is registered in the output register when the item is accepted.
// Throughput is one item per cycle while out_ready stays high, set by the
// single output register and the compare and shift across the cell row.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; in_ready is high again in the cycle it
// is taken. Reset empties the list and clears out_valid; no clearing
// pass is needed and items are accepted right after reset.
// Depends on ovl_pkg, ovl_cell and ordered_value_list_macros.svh.
`include "ordered_value_list_macros.svh"

module ordered_value_list
	import ovl_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int               CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_nxt;
	logic                  out_valid_q;
	out_item_t             out_item_q;
	logic                  fire;
	logic                  found;
	logic                  not_full;
	logic                  success;
	logic                  reject;
	logic [VALUE_BITS-1:0] value_ext;
	ovl_cmd_t              cmd;
	logic [VALUE_BITS-1:0] cell_data [CAPACITY];
	logic [CAPACITY:0]     match;

	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign value_ext = VALUE_BITS'(in_item.value);
	assign cmd.en    = fire;
	assign cmd.op    = in_item.op;
	assign match[0]  = 1'b0;
	assign found     = match[CAPACITY];
	assign not_full  = cnt_q != CAP_C;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] next_data;
		if (i == CAPACITY - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_inner
			assign next_data = cell_data[i+1];
		end
		ovl_cell #(
			.VALUE_BITS(VALUE_BITS),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.value    (value_ext),
			.cnt      (cnt_q),
			.next_data(next_data),
			.match_in (match[i]),
			.match_out(match[i+1]),
			.data     (cell_data[i])
		);
	end

	always_comb begin
		success = 1'b0;
		reject  = 1'b0;
		cnt_nxt = cnt_q;
		unique case (in_item.op)
			OP_APPEND: begin
				success = not_full;
				reject  = !not_full;
				if (not_full) begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				success = found;
				if (found) begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			OP_CONTAINS: begin
				success = found;
			end
			OP_CLEAR: begin
				success = 1'b1;
				cnt_nxt = '0;
			end
			default: begin
				success = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q.success     <= success;
			out_item_q.full_reject <= reject;
			out_item_q.entry_count <= 5'(cnt_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`OVL_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_C)
	`OVL_ASSERT_IMPL(a_flags_excl, clk, arst_n, out_valid_q,
		!(out_item_q.success && out_item_q.full_reject))
	`OVL_ASSERT_NEXT(a_full_reject, clk, arst_n,
		fire && in_item.op == OP_APPEND && cnt_q == CAP_C,
		out_valid_q && out_item_q.full_reject && cnt_q == CAP_C)
	`OVL_ASSERT_NEXT(a_clear, clk, arst_n, fire && in_item.op == OP_CLEAR,
		out_valid_q && out_item_q.success && cnt_q == '0)

endmodule
